// ===== hdl/wma3_pkg.sv =====
// Shared types and constants for the three-channel weighted moving average.
`timescale 1ns / 1ps

package wma3_pkg;

  // Channel and weight counts
  localparam int NUM_CH      = 3;
  localparam int NUM_WEIGHTS = 4;
  localparam int WEIGHT_W    = 8;
  // Weight sum of four 8-bit weights fits in 10 bits
  localparam int WSUM_W      = 10;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3 = 2'd3;

  // Weight reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_0_RST = 8'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_1_RST = 8'd2;
  localparam logic [WEIGHT_W-1:0] WEIGHT_2_RST = 8'd3;
  localparam logic [WEIGHT_W-1:0] WEIGHT_3_RST = 8'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } wma3_state_t;

endpackage

// ===== hdl/wma3_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, with a small divisor.
`timescale 1ns / 1ps

module wma3_div
  import wma3_pkg::*;
#(
  parameter int Q_W = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [Q_W+WSUM_W-1:0] num,
  input  logic [WSUM_W-1:0]     den,
  output logic                  done,
  output logic [Q_W-1:0]        quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WSUM_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic [WSUM_W-1:0] den_r;
  logic [WSUM_W:0]   trial;
  logic              fits;

  // Shift in the next numerator bit and try the subtract
  assign trial = {rem_r, quo_r[Q_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      // High part of the numerator is below the divisor, since the quotient fits Q_W bits
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(Q_W);
      rem_nxt  = num[Q_W+WSUM_W-1 -: WSUM_W];
      quo_nxt  = num[Q_W-1:0];
    end else if (busy_r) begin
      rem_nxt = fits ? WSUM_W'(trial - {1'b0, den_r}) : trial[WSUM_W-1:0];
      quo_nxt = {quo_r[Q_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath needs no reset
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/weighted_moving_average_3ch.sv =====
// Top level of the three-channel weighted moving average.
`timescale 1ns / 1ps

// Each accepted request carries one height, pressure and temperature sample. The samples
// enter per-channel rings of DEPTH entries; the result is, per channel, the weighted sum of
// the held samples (oldest weighted by weight_0, up to four weights) divided by the weight
// sum, rounded to nearest with ties away from zero, or 0 if the weight sum is zero. One
// multiply-accumulate unit and one restoring divider are shared by the channels under a
// sequencer: for each channel in turn, the held samples, up to four taps, pass through the
// multiply-accumulate unit, and the sum then goes to the divider, one quotient bit a cycle,
// unless the weight sum is zero. in_tready is low while a request is
// being worked on; a finished result sits in the output register, so the next request can
// be taken while it waits for out_tready. Weights may be written only while the block is idle.
module weighted_moving_average_3ch
  import wma3_pkg::*;
#(
  parameter int DEPTH       = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input: height_in, pressure_in, temperature_in (low bits first)
  input  logic [((NUM_CH*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Output: height_avg, pressure_avg, temperature_avg (low bits first)
  output logic [((NUM_CH*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Weight register write port
  input  logic                                cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [WEIGHT_W-1:0]                 cfg_wdata
);

  localparam int S       = SAMPLE_BITS;
  localparam int BUS_W   = ((NUM_CH*S+7)/8)*8;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int TAP_W   = 3;
  localparam int K_W     = 2;
  localparam int CH_W    = 2;
  localparam int PROD_W  = S + WEIGHT_W + 1;
  localparam int ACC_W   = S + WSUM_W + 1;
  localparam int NUM_W   = S + WSUM_W;

  wma3_state_t state_r, state_nxt;

  logic [WEIGHT_W-1:0] weights_r [NUM_WEIGHTS];
  logic [S-1:0]        ring_r    [NUM_CH][DEPTH];
  logic [S-1:0]        res_r     [NUM_CH];
  logic [S-1:0]        sample    [NUM_CH];

  logic [SLOT_W-1:0] wslot_r, wslot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [TAP_W-1:0]  ntap_r, ntap_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BUS_W-1:0]  out_data_r;

  logic              in_fire;
  logic              out_load;
  logic [FILL_W:0]   oldest_ext;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  mag_ext;
  logic [NUM_W-1:0]  div_num;
  logic              div_start;
  logic              div_done;
  logic [S-1:0]      div_quo;
  logic              ch_fin;
  logic [S-1:0]      ch_res;

  // Unpack the input request
  assign sample[0] = in_tdata[S-1:0];
  assign sample[1] = in_tdata[2*S-1:S];
  assign sample[2] = in_tdata[3*S-1:2*S];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Ring pointers after this request
  always_comb begin
    wslot_nxt = (wslot_r == SLOT_W'(DEPTH - 1)) ? '0 : wslot_r + SLOT_W'(1);
    fill_nxt  = (fill_r == FILL_W'(DEPTH)) ? fill_r : fill_r + FILL_W'(1);
    oldest_ext = {{(FILL_W + 1 - SLOT_W){1'b0}}, wslot_nxt} + (FILL_W + 1)'(DEPTH)
                 - {1'b0, fill_nxt};
    if (oldest_ext >= (FILL_W + 1)'(DEPTH)) begin
      oldest_ext = oldest_ext - (FILL_W + 1)'(DEPTH);
    end
    oldest_nxt = oldest_ext[SLOT_W-1:0];
    ntap_nxt   = (int'(fill_nxt) < NUM_WEIGHTS) ? TAP_W'(fill_nxt) : TAP_W'(NUM_WEIGHTS);
  end

  // Weight sum over the held taps
  always_comb begin
    wsum_nxt = '0;
    for (int j = 0; j < NUM_WEIGHTS; j++) begin
      if (TAP_W'(j) < ntap_nxt) begin
        wsum_nxt = wsum_nxt + WSUM_W'(weights_r[j]);
      end
    end
  end

  // Shared multiply-accumulate: one tap a cycle
  assign prod = $signed({1'b0, weights_r[k_r]}) * $signed(ring_r[ch_r][rd_ptr_r]);

  // Rounded numerator: magnitude plus half the divisor
  assign mag_ext = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;
  assign div_num = mag_ext[NUM_W-1:0] + NUM_W'(wsum_r >> 1);

  wma3_div #(
    .Q_W (S)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (wsum_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    k_nxt         = k_r;
    ch_nxt        = ch_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    div_start     = 1'b0;
    ch_fin        = 1'b0;
    ch_res        = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rd_ptr_nxt = oldest_nxt;
          k_nxt      = '0;
          ch_nxt     = '0;
          acc_nxt    = '0;
          state_nxt  = ST_MAC;
        end
      end
      ST_MAC: begin
        acc_nxt    = acc_r + ACC_W'($signed(prod));
        k_nxt      = k_r + K_W'(1);
        rd_ptr_nxt = (rd_ptr_r == SLOT_W'(DEPTH - 1)) ? '0 : rd_ptr_r + SLOT_W'(1);
        if ({1'b0, k_r} == ntap_r - TAP_W'(1)) begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        neg_nxt = acc_r[ACC_W-1];
        if (wsum_r == '0) begin
          // Zero weight sum gives zero
          ch_fin = 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          ch_fin = 1'b1;
          ch_res = neg_r ? S'(-div_quo) : div_quo;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Advance to the next channel or finish
    if (ch_fin) begin
      if (ch_r == CH_W'(NUM_CH - 1)) begin
        state_nxt = ST_DONE;
      end else begin
        ch_nxt     = ch_r + CH_W'(1);
        k_nxt      = '0;
        rd_ptr_nxt = oldest_r;
        acc_nxt    = '0;
        state_nxt  = ST_MAC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wslot_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        wslot_r <= wslot_nxt;
        fill_r  <= fill_nxt;
      end
    end
  end

  // Weight registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r[0] <= WEIGHT_0_RST;
      weights_r[1] <= WEIGHT_1_RST;
      weights_r[2] <= WEIGHT_2_RST;
      weights_r[3] <= WEIGHT_3_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WEIGHT_0: weights_r[0] <= cfg_wdata;
        REG_WEIGHT_1: weights_r[1] <= cfg_wdata;
        REG_WEIGHT_2: weights_r[2] <= cfg_wdata;
        REG_WEIGHT_3: weights_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Datapath registers and rings
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    k_r      <= k_nxt;
    ch_r     <= ch_nxt;
    acc_r    <= acc_nxt;
    neg_r    <= neg_nxt;
    if (in_fire) begin
      oldest_r <= oldest_nxt;
      ntap_r   <= ntap_nxt;
      wsum_r   <= wsum_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        ring_r[c][wslot_r] <= sample[c];
      end
    end
    if (ch_fin) begin
      res_r[ch_r] <= ch_res;
    end
    if (out_load) begin
      out_data_r <= BUS_W'({res_r[2], res_r[1], res_r[0]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== verif/tb_weighted_moving_average_3ch.sv =====
// Self-checking testbench for the three-channel weighted moving average.
`timescale 1ns / 1ps

module tb_weighted_moving_average_3ch
  import wma3_pkg::*;
();

  localparam int DEPTH           = 4;
  localparam int SAMPLE_BITS     = 24;
  localparam int DATA_W          = ((NUM_CH*SAMPLE_BITS+7)/8)*8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 7;
  // Receiver backpressure and quiet windows; HOLD_AT, CALM_FROM and CALM_TO count accepted results
  localparam int HOLD_AT         = 200;
  localparam int HOLD_CYCLES     = 400;
  localparam int CALM_FROM       = 500;
  localparam int CALM_TO         = 650;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 100;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  // One request or one result: height in the low bits, temperature on top
  typedef struct packed {
    sample_t temperature;
    sample_t pressure;
    sample_t height;
  } triple_t;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Tracks the sample rings and weights, and checks each result in order
  class wma3_scoreboard;
    logic [WEIGHT_W-1:0] weight [NUM_WEIGHTS];
    sample_t             ring [NUM_CH][DEPTH];
    int unsigned         slot;
    int unsigned         held;
    triple_t             avg_q [$];
    string               avg_name [NUM_CH];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         zero_sums;

    function new();
      weight[0]   = WEIGHT_0_RST;
      weight[1]   = WEIGHT_1_RST;
      weight[2]   = WEIGHT_2_RST;
      weight[3]   = WEIGHT_3_RST;
      avg_name[0] = "height_avg";
      avg_name[1] = "pressure_avg";
      avg_name[2] = "temperature_avg";
      slot        = 0;
      held        = 0;
      errors      = 0;
      checked     = 0;
      zero_sums   = 0;
    endfunction

    function void set_weight(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] value);
      weight[idx] = value;
    endfunction

    function int unsigned pending();
      return avg_q.size();
    endfunction

    // Push one request into the rings and queue its three rounded averages
    function void note_samples(triple_t s);
      longint      wsum;
      longint      acc;
      longint      mag;
      longint      q;
      int unsigned oldest;
      triple_t     res;
      for (int c = 0; c < NUM_CH; c++) begin
        ring[c][slot] = s[c*SAMPLE_BITS +: SAMPLE_BITS];
      end
      slot = (slot + 1) % DEPTH;
      if (held < DEPTH) held++;
      oldest = (slot + DEPTH - held) % DEPTH;
      // Oldest held sample takes weight_0; recency positions past four weigh nothing
      wsum = 0;
      for (int k = 0; k < held; k++) begin
        if (k < NUM_WEIGHTS) wsum += longint'(weight[k]);
      end
      if (wsum == 0) zero_sums++;
      res = '0;
      for (int c = 0; c < NUM_CH; c++) begin
        acc = 0;
        for (int k = 0; k < held; k++) begin
          if (k < NUM_WEIGHTS) begin
            acc += longint'(weight[k]) * longint'(ring[c][(oldest + k) % DEPTH]);
          end
        end
        // Round half away from zero on the magnitude
        if (wsum != 0) begin
          mag = (acc < 0) ? -acc : acc;
          q   = (mag + wsum / 2) / wsum;
          res[c*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'((acc < 0) ? -q : q);
        end
      end
      avg_q.push_back(res);
    endfunction

    // Compare one accepted result against the oldest queued averages
    function void check_result(triple_t got);
      triple_t want;
      sample_t exp_v;
      sample_t act_v;
      if (avg_q.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = avg_q.pop_front();
      checked++;
      for (int c = 0; c < NUM_CH; c++) begin
        exp_v = want[c*SAMPLE_BITS +: SAMPLE_BITS];
        act_v = got[c*SAMPLE_BITS +: SAMPLE_BITS];
        if (act_v !== exp_v) begin
          $error("%s: expected %0d, got %0d", avg_name[c], exp_v, act_v);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic [DATA_W-1:0]    in_tdata   = '0;  // height_in, pressure_in, temperature_in
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    out_tdata;        // height_avg, pressure_avg, temperature_avg
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_WEIGHT_0;
  logic [WEIGHT_W-1:0]  cfg_wdata  = '0;

  wma3_scoreboard avg_board = new();

  int unsigned requests_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_used = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  bit          hold_done     = 1'b0;
  bit          calm_tx       = 1'b0;

  weighted_moving_average_3ch #(
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Check results and drive out_tready: random stalls, one long hold, one calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        avg_board.check_result(out_tdata);
        results_seen++;
      end
      if (results_seen == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 25);
      end
    end
  end

  // End the run when neither side has moved a request for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", avg_board.pending());
      $display("tb_weighted_moving_average_3ch: done, errors");
      $finish;
    end
  end

  // Write all four weights, one per cycle
  task automatic write_weights(input logic [WEIGHT_W-1:0] w0, w1, w2, w3);
    logic [WEIGHT_W-1:0]  w [NUM_WEIGHTS];
    logic [CFG_IDX_W-1:0] idx [NUM_WEIGHTS];
    w   = '{w0, w1, w2, w3};
    idx = '{REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3};
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= w[i];
      @(posedge clk);
      avg_board.set_weight(idx[i], w[i]);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Offer one request after random idle cycles and hold it until taken
  task automatic send_samples(input triple_t s);
    while (!calm_tx && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    avg_board.note_samples(s);
    requests_sent++;
  endtask

  // Stop offering and wait until every queued result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (avg_board.pending() != 0) @(posedge clk);
  endtask

  // Mix of full-range, small, extreme and near-extreme samples
  function automatic sample_t rand_sample();
    int unsigned pick;
    sample_t     r;
    pick = $urandom_range(99);
    r    = sample_t'($urandom_range(255));
    if (pick < 50) return sample_t'($urandom);
    if (pick < 70) return sample_t'(int'($urandom_range(2000)) - 1000);
    if (pick < 85) begin
      case ($urandom_range(3))
        0:       return S_MAX;
        1:       return S_MIN;
        2:       return sample_t'(0);
        default: return sample_t'(-1);
      endcase
    end
    return $urandom_range(1) ? sample_t'(S_MAX - r) : sample_t'(S_MIN + r);
  endfunction

  function automatic triple_t rand_triple();
    triple_t t;
    t.height      = rand_sample();
    t.pressure    = rand_sample();
    t.temperature = rand_sample();
    return t;
  endfunction

  // Weights lean on zero and full scale
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) return '0;
    if (pick < 50) return '1;
    return WEIGHT_W'($urandom_range(255));
  endfunction

  initial begin
    logic [WEIGHT_W-1:0] w [NUM_WEIGHTS];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset weights: fill the rings from empty with extremes, then wrap
    send_samples('{height: S_MAX, pressure: S_MIN, temperature: 0});
    send_samples('{height: S_MIN, pressure: 0, temperature: S_MAX});
    send_samples('{height: -1, pressure: S_MAX, temperature: S_MIN});
    send_samples('{height: S_MAX, pressure: S_MAX, temperature: S_MIN});
    send_samples('{height: S_MIN, pressure: -1, temperature: 1});
    drain();

    // Full-scale weights on full-scale samples
    write_weights('1, '1, '1, '1);
    send_samples('{height: S_MAX, pressure: S_MAX, temperature: S_MAX});
    send_samples('{height: S_MIN, pressure: S_MIN, temperature: S_MIN});
    drain();

    // Zero weight sum gives zero on every channel
    write_weights('0, '0, '0, '0);
    send_samples('{height: S_MAX, pressure: S_MIN, temperature: 5});
    drain();

    // Equal weights: exact halves round away from zero
    write_weights(8'd1, 8'd1, 8'd1, 8'd1);
    send_samples('{height: 0, pressure: 0, temperature: 0});
    send_samples('{height: 0, pressure: 0, temperature: 0});
    send_samples('{height: 0, pressure: 0, temperature: 0});
    send_samples('{height: 2, pressure: -2, temperature: 1});
    send_samples('{height: -2, pressure: 2, temperature: 3});
    drain();

    // Random phases, each under its own weight setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1:       w = '{'1, '1, '1, '1};
        2:       w = '{'0, '0, '0, '0};
        3:       w = '{'0, '0, '0, '1};
        4:       w = '{WEIGHT_W'($urandom_range(3)), WEIGHT_W'($urandom_range(3)),
                       WEIGHT_W'($urandom_range(3)), WEIGHT_W'($urandom_range(3))};
        5:       w = '{'1, '0, '0, '0};
        default: w = '{rand_weight(), rand_weight(), rand_weight(), rand_weight()};
      endcase
      write_weights(w[0], w[1], w[2], w[3]);
      calm_tx = (ph == 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_samples(rand_triple());
        // Hold off mid-phase once until the block has emptied
        if (ph == 0 && i == ITEMS_PER_PHASE / 2) drain();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests, checked %0d results across %0d weight settings.",
             requests_sent, avg_board.checked, settings_used);
    $display("Run included %0d zero-weight-sum results, full-scale samples and exact halves.",
             avg_board.zero_sums);
    if (avg_board.errors == 0 && avg_board.pending() == 0) begin
      $display("tb_weighted_moving_average_3ch: done, clean");
    end else begin
      $display("tb_weighted_moving_average_3ch: done, errors");
    end
    $finish;
  end

endmodule
